// File: src/cham_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cham_pkg
// Shared sizes, types and codes for the clipped Hebbian associative memory.
// ---------------------------------------------------------------------------
package cham_pkg;

   localparam int KEY_LEN    = 64;
   localparam int OUT_LEN    = 32;
   localparam int VALUE_BITS = 8;
   localparam int FRAC_BITS  = VALUE_BITS - 1;

   // port field widths
   localparam int CMD_W = 2;
   localparam int IDX_W = 6;
   localparam int VAL_W = 8;
   localparam int OIX_W = 5;

   localparam int KEY_AW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
   localparam int OUT_AW = (OUT_LEN > 1) ? $clog2(OUT_LEN) : 1;
   localparam int THR_W  = VALUE_BITS + $clog2(KEY_LEN + 1);
   localparam int ACC_W  = 2 * VALUE_BITS + $clog2(KEY_LEN + 1);
   localparam int PIPE_DEPTH = 4;
   localparam int CNT_W  = $clog2(KEY_LEN + PIPE_DEPTH + 1);

   localparam logic [VALUE_BITS-1:0] VAL_ONE = VALUE_BITS'(1) << FRAC_BITS;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_KEY = 2'd0,
      CMD_LOAD_TGT = 2'd1,
      CMD_RUN      = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_RUN,
      ST_CAPTURE,
      ST_EMIT
   } state_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic              clear;    // write zero at rd_addr
      logic              rd_en;    // issue a weight row read
      logic [KEY_AW-1:0] rd_addr;
      logic              learn;    // write back updated weights
      logic              acc_clr;
      logic              capture;  // latch the recalled bit
      logic              shift;    // move recalled bits one cell toward the head
   } cell_ctrl_type;

endpackage

// File: src/clipped_hebbian_assoc_memory_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_hebbian_assoc_memory_unit
// Hetero-associative memory with clipped Hebbian learning and threshold
// recall, built as a row of column cells.
// ---------------------------------------------------------------------------
// After reset the unit clears the key and weight memories and accepts no
// beat until the clear pass is done. Key and target loads are single beats. A
// run first sums the key from its memory into the threshold, then streams
// every key row through the cells (one row a cycle, four-stage multiply
// pipeline), compares each column sum with the threshold, and then emits
// OUT_LEN result beats, one per cycle while rsp_ready is high. Only one run
// is in flight at a time.
module clipped_hebbian_assoc_memory_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [cham_pkg::CMD_W-1:0]   req_cmd,
   input  logic [cham_pkg::IDX_W-1:0]   req_elem_index,
   input  logic [cham_pkg::VAL_W-1:0]   req_elem_value,
   input  logic                         req_learn_enable,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [cham_pkg::OIX_W-1:0]   rsp_out_index,
   output logic                         rsp_out_bit,
   output logic                         rsp_last_flag
);
   import cham_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [OUT_AW-1:0]     oix_ff, oix_in;
   logic                  learn_ff, learn_in;
   logic [THR_W-1:0]      thr_ff;
   logic                  ksv_ff;
   logic [VALUE_BITS-1:0] kmem [KEY_LEN];
   logic [VALUE_BITS-1:0] key_rd_ff;
   logic                  key_rd_en;
   logic                  req_fire, rsp_fire;
   logic                  key_we;
   logic [KEY_AW-1:0]     key_waddr;
   logic [VALUE_BITS-1:0] key_wdata;
   logic [VALUE_BITS-1:0] in_value;
   logic                  thr_nz;
   logic [ACC_W-1:0]      thr_scaled;
   cell_ctrl_type         ctrl;
   logic [OUT_LEN:0]      chain;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;
   assign in_value = req_elem_value[VALUE_BITS-1:0];

   // hold state, counters and run flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         oix_ff   <= '0;
         learn_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         oix_ff   <= oix_in;
         learn_ff <= learn_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      oix_in   = oix_ff;
      learn_in = learn_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(KEY_LEN - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_cmd == CMD_RUN) begin
               state_in = ST_SUM;
               cnt_in   = '0;
               learn_in = req_learn_enable;
            end
         end
         ST_SUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(KEY_LEN)) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(KEY_LEN + PIPE_DEPTH - 1)) begin
               state_in = ST_CAPTURE;
               cnt_in   = '0;
            end
         end
         ST_CAPTURE: begin
            state_in = ST_EMIT;
            oix_in   = '0;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               oix_in = oix_ff + 1'b1;
               if (oix_ff == OUT_AW'(OUT_LEN - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and cell control
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      key_rd_en    = 1'b0;
      ctrl         = '0;
      ctrl.rd_addr = cnt_ff[KEY_AW-1:0];
      ctrl.learn   = learn_ff & thr_nz;
      case (state_ff)
         ST_CLEAR:   ctrl.clear = 1'b1;
         ST_IDLE:    req_ready = 1'b1;
         ST_SUM: begin
            key_rd_en    = (cnt_ff < CNT_W'(KEY_LEN));
            ctrl.acc_clr = 1'b1;
         end
         ST_RUN: begin
            key_rd_en  = (cnt_ff < CNT_W'(KEY_LEN));
            ctrl.rd_en = key_rd_en;
         end
         ST_CAPTURE: ctrl.capture = 1'b1;
         ST_EMIT: begin
            rsp_valid  = 1'b1;
            ctrl.shift = rsp_ready;
         end
         default: ;
      endcase
   end

   // key memory: clear pass, loads, and row reads
   assign key_we    = ctrl.clear
                    | (req_fire && req_cmd == CMD_LOAD_KEY
                       && 32'(req_elem_index) < KEY_LEN);
   assign key_waddr = ctrl.clear ? cnt_ff[KEY_AW-1:0] : KEY_AW'(req_elem_index);
   assign key_wdata = ctrl.clear ? '0 : in_value;

   always_ff @(posedge clock) begin
      if (key_we) begin
         kmem[key_waddr] <= key_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (key_rd_en) begin
         key_rd_ff <= kmem[cnt_ff[KEY_AW-1:0]];
      end
   end

   // sum the key into the threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         ksv_ff <= 1'b0;
         thr_ff <= '0;
      end else begin
         ksv_ff <= key_rd_en & (state_ff == ST_SUM);
         if (req_fire && req_cmd == CMD_RUN) begin
            thr_ff <= '0;
         end else if (ksv_ff) begin
            thr_ff <= thr_ff + THR_W'(key_rd_ff);
         end
      end
   end

   assign thr_nz     = (thr_ff != '0);
   assign thr_scaled = ACC_W'(thr_ff) << FRAC_BITS;

   // row of column cells; recalled bits drain toward cell zero
   assign chain[OUT_LEN] = 1'b0;

   for (genvar j = 0; j < OUT_LEN; j++) begin : g_cell
      cham_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .tgt_we     (req_fire && req_cmd == CMD_LOAD_TGT
                      && 32'(req_elem_index) == j),
         .tgt_value  (in_value),
         .key_value  (key_rd_ff),
         .thr_nz     (thr_nz),
         .thr_scaled (thr_scaled),
         .shift_in   (chain[j+1]),
         .shift_out  (chain[j])
      );
   end

   assign rsp_out_bit   = chain[0];
   assign rsp_out_index = OIX_W'(oix_ff);
   assign rsp_last_flag = (oix_ff == OUT_AW'(OUT_LEN - 1));

endmodule

// File: src/cham_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cham_cell
// One output column: holds its target element and one weight per key row,
// learns and accumulates one row per cycle, and passes its recalled bit on
// to its neighbor during readout.
// ---------------------------------------------------------------------------
module cham_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  cham_pkg::cell_ctrl_type            ctrl,
   input  logic                               tgt_we,
   input  logic [cham_pkg::VALUE_BITS-1:0]    tgt_value,
   input  logic [cham_pkg::VALUE_BITS-1:0]    key_value,
   input  logic                               thr_nz,
   input  logic [cham_pkg::ACC_W-1:0]         thr_scaled,
   input  logic                               shift_in,
   output logic                               shift_out
);
   import cham_pkg::*;

   logic [VALUE_BITS-1:0]   wmem [KEY_LEN];
   logic [VALUE_BITS-1:0]   tgt_ff;
   logic [VALUE_BITS-1:0]   w_rd_ff;
   logic [KEY_AW-1:0]       addr1_ff, addr2_ff;
   logic                    v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2*VALUE_BITS-1:0] prod1_in, prod1_ff;
   logic [VALUE_BITS-1:0]   w1_ff, key1_ff;
   logic [VALUE_BITS-1:0]   w2_ff, key2_ff;
   logic [2*VALUE_BITS-1:0] prod2_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic [VALUE_BITS+1:0]   w_sum;
   logic [VALUE_BITS-1:0]   w_new;
   logic                    wr_en;
   logic [KEY_AW-1:0]       wr_addr;
   logic [VALUE_BITS-1:0]   wr_data;
   logic                    res_ff;

   // hold the target element
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= '0;
      end else if (tgt_we) begin
         tgt_ff <= tgt_value;
      end
   end

   // advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // read the weight row
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         w_rd_ff <= wmem[ctrl.rd_addr];
      end
      addr1_ff <= ctrl.rd_addr;
   end

   // learning product key * target
   assign prod1_in = key_value * tgt_ff;

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      w1_ff    <= w_rd_ff;
      key1_ff  <= key_value;
      addr2_ff <= addr1_ff;
   end

   // add truncated product and clip at one
   always_comb begin
      w_sum = (VALUE_BITS+2)'(w1_ff) + (VALUE_BITS+2)'(prod1_ff >> FRAC_BITS);
      if (!ctrl.learn) begin
         w_new = w1_ff;
      end else if (w_sum > (VALUE_BITS+2)'(VAL_ONE)) begin
         w_new = VAL_ONE;
      end else begin
         w_new = w_sum[VALUE_BITS-1:0];
      end
   end

   // write port: clearing pass or learned weight
   assign wr_en   = ctrl.clear | (v2_ff & ctrl.learn);
   assign wr_addr = ctrl.clear ? ctrl.rd_addr : addr2_ff;
   assign wr_data = ctrl.clear ? '0 : w_new;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_addr] <= wr_data;
      end
   end

   // recall product weight * key
   always_ff @(posedge clock) begin
      w2_ff    <= w_new;
      key2_ff  <= key1_ff;
      prod2_ff <= w2_ff * key2_ff;
   end

   // accumulate the column sum
   always_ff @(posedge clock) begin
      if (reset || ctrl.acc_clr) begin
         acc_ff <= '0;
      end else if (v4_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod2_ff);
      end
   end

   // latch the recalled bit, then shift toward the head
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= 1'b0;
      end else if (ctrl.capture) begin
         res_ff <= thr_nz & (acc_ff >= thr_scaled);
      end else if (ctrl.shift) begin
         res_ff <= shift_in;
      end
   end

   assign shift_out = res_ff;

endmodule
